// ===== sv/sdtq_pkg.sv =====
package sdtq_pkg;

    // Size of the queue and the limit on entries fired by one tick.
    localparam int DEPTH    = 16;
    localparam int MAX_FIRE = 16;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FIRE_W = $clog2(MAX_FIRE);

    localparam int SEC_W = 32;
    localparam int NS_W  = 30;
    localparam int ID_W  = 16;

    // Largest nanoseconds value a schedule request may carry.
    localparam logic [NS_W-1:0] NS_LIMIT = NS_W'(1000000000);

    // Request commands.
    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_SCHEDULED = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FIRED     = 3'd5;

    // One timer entry held by a cell.
    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  ns;
        logic [ID_W-1:0]  id;
    } entry_t;

    // What a cell does at the next clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    // Compare results a cell reports to the control logic.
    typedef struct packed {
        logic later;
        logic id_hit;
    } cell_flags_t;

endpackage

// ===== sv/sdtq_cell.sv =====
module sdtq_cell
(
    input  logic                              clk,
    input  sdtq_pkg::cell_op_t                op,
    input  sdtq_pkg::entry_t                  new_entry,
    input  sdtq_pkg::entry_t                  left_entry,
    input  sdtq_pkg::entry_t                  right_entry,
    input  logic [sdtq_pkg::SEC_W-1:0]        req_sec,
    input  logic [sdtq_pkg::NS_W-1:0]         req_ns,
    input  logic [sdtq_pkg::ID_W-1:0]         req_id,
    output sdtq_pkg::entry_t                  entry,
    output sdtq_pkg::cell_flags_t             flags
);

    sdtq_pkg::entry_t entry_reg;

    // later: the stored deadline is strictly later than the request time; id_hit: the ids match.
    always_comb
    begin
        flags.later  = (entry_reg.sec > req_sec) ||
                       ((entry_reg.sec == req_sec) && (entry_reg.ns > req_ns));
        flags.id_hit = (entry_reg.id == req_id);
    end

    // Entry storage: hold, take the new entry, or shift from a neighbor.
    always_ff @(posedge clk)
    begin
        unique case (op)
            sdtq_pkg::CELL_HOLD:       entry_reg <= entry_reg;
            sdtq_pkg::CELL_LOAD:       entry_reg <= new_entry;
            sdtq_pkg::CELL_FROM_LEFT:  entry_reg <= left_entry;
            sdtq_pkg::CELL_FROM_RIGHT: entry_reg <= right_entry;
            default:                   entry_reg <= entry_reg;
        endcase
    end

    assign entry = entry_reg;

endmodule

// ===== sv/sorted_deadline_timer_queue.sv =====
// Sorted timer queue built as a row of cells, earliest deadline at cell 0.
// One request is taken at a time: s_tready is high only while the block is
// idle. Schedule and cancel first register the request; then every cell
// compares its deadline or id against it and the row shifts right (insert)
// or left (remove) in place. A tick registers the request and then fires
// entries through the head cell, one per clock while the output register is
// free. Each result waits in an output register, and a stalled m_tready
// holds the block in its execute state until that register is free.
module sorted_deadline_timer_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] time_seconds, [61:32] time_nanoseconds, [77:62] timer_id, [79:78] zero
    input  logic [79:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] result_id
    output logic [15:0] m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser,
    // last_result
    output logic        m_tlast
);

    localparam int DEPTH  = sdtq_pkg::DEPTH;
    localparam int CNT_W  = sdtq_pkg::CNT_W;
    localparam int FIRE_W = sdtq_pkg::FIRE_W;
    localparam int ID_W   = sdtq_pkg::ID_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                       state_reg;
    logic [1:0]                   req_cmd_reg;
    logic [sdtq_pkg::SEC_W-1:0]   req_sec_reg;
    logic [sdtq_pkg::NS_W-1:0]    req_ns_reg;
    logic [ID_W-1:0]              req_id_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [ID_W-1:0]              next_id_reg;
    logic [FIRE_W-1:0]            fire_cnt_reg;
    logic                         out_valid_reg;
    logic [2:0]                   out_status_reg;
    logic [ID_W-1:0]              out_id_reg;
    logic                         out_last_reg;

    sdtq_pkg::entry_t             cell_q [DEPTH];
    sdtq_pkg::cell_flags_t        flags [DEPTH];
    sdtq_pkg::cell_op_t           ops [DEPTH];
    sdtq_pkg::entry_t             new_entry;

    logic [ID_W-1:0]              new_id;
    logic [DEPTH-1:0]             occ;
    logic [DEPTH-1:0]             go;
    logic [DEPTH-1:0]             go_left;
    logic [DEPTH-1:0]             hit;
    logic [DEPTH-1:0]             rm;
    logic                         slot_free;
    logic                         exec;
    logic                         ns_bad;
    logic                         full;
    logic                         due0;
    logic                         due1;
    logic                         fire_last;
    logic                         do_insert;
    logic                         do_cancel;
    logic                         do_fire;

    // Next id to hand out, skipping zero on wrap.
    always_comb
    begin
        new_id = next_id_reg + ID_W'(1);
        if (new_id == '0)
        begin
            new_id = ID_W'(1);
        end
    end

    assign new_entry = '{sec: req_sec_reg, ns: req_ns_reg, id: new_id};

    // The cell row.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        sdtq_pkg::entry_t left_e;
        sdtq_pkg::entry_t right_e;

        if (g == 0)
        begin : g_head
            assign left_e = new_entry;
        end
        else
        begin : g_mid_l
            assign left_e = cell_q[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign right_e = new_entry;
        end
        else
        begin : g_mid_r
            assign right_e = cell_q[g+1];
        end

        sdtq_cell u_cell
        (
            .clk         (clk),
            .op          (ops[g]),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .req_sec     (req_sec_reg),
            .req_ns      (req_ns_reg),
            .req_id      (req_id_reg),
            .entry       (cell_q[g]),
            .flags       (flags[g])
        );
    end

    // Occupancy, insert position and cancel position across the row.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            occ[i] = (CNT_W'(i) < count_reg);
            go[i]  = !occ[i] || flags[i].later;
            hit[i] = occ[i] && flags[i].id_hit && (req_id_reg != '0);
        end
        go_left[0] = 1'b0;
        rm[0]      = hit[0];
        for (int i = 1; i < DEPTH; i++)
        begin
            go_left[i] = go[i-1];
            rm[i]      = rm[i-1] | hit[i];
        end
    end

    // Request decode for the current execute cycle.
    assign slot_free = !out_valid_reg || m_tready;
    assign exec      = (state_reg == S_EXEC);
    assign ns_bad    = (req_ns_reg > sdtq_pkg::NS_LIMIT);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign due0      = occ[0] && !flags[0].later;
    assign due1      = occ[1] && !flags[1].later;
    assign fire_last = !due1 || (fire_cnt_reg == FIRE_W'(sdtq_pkg::MAX_FIRE - 1));

    assign do_insert = exec && (req_cmd_reg == sdtq_pkg::CMD_SCHEDULE) && slot_free &&
                       !ns_bad && !full;
    assign do_cancel = exec && (req_cmd_reg == sdtq_pkg::CMD_CANCEL) && slot_free &&
                       rm[DEPTH-1];
    assign do_fire   = exec && (req_cmd_reg == sdtq_pkg::CMD_TICK) && slot_free && due0;

    // Per-cell operation.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            ops[i] = sdtq_pkg::CELL_HOLD;
            if (do_insert)
            begin
                if (go[i] && go_left[i])
                begin
                    ops[i] = sdtq_pkg::CELL_FROM_LEFT;
                end
                else if (go[i])
                begin
                    ops[i] = sdtq_pkg::CELL_LOAD;
                end
            end
            else if (do_cancel)
            begin
                if (rm[i])
                begin
                    ops[i] = sdtq_pkg::CELL_FROM_RIGHT;
                end
            end
            else if (do_fire)
            begin
                ops[i] = sdtq_pkg::CELL_FROM_RIGHT;
            end
        end
    end

    // Control state, request capture and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            next_id_reg   <= '0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        req_cmd_reg  <= s_tuser;
                        req_sec_reg  <= s_tdata[31:0];
                        req_ns_reg   <= s_tdata[61:32];
                        req_id_reg   <= s_tdata[77:62];
                        fire_cnt_reg <= '0;
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (req_cmd_reg)
                        sdtq_pkg::CMD_SCHEDULE:
                        begin
                            if (slot_free)
                            begin
                                out_valid_reg <= 1'b1;
                                out_last_reg  <= 1'b1;
                                if (ns_bad)
                                begin
                                    out_status_reg <= sdtq_pkg::ST_INVALID;
                                    out_id_reg     <= '0;
                                end
                                else if (full)
                                begin
                                    out_status_reg <= sdtq_pkg::ST_FULL;
                                    out_id_reg     <= '0;
                                end
                                else
                                begin
                                    out_status_reg <= sdtq_pkg::ST_SCHEDULED;
                                    out_id_reg     <= new_id;
                                    next_id_reg    <= new_id;
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                                state_reg <= S_IDLE;
                            end
                        end
                        sdtq_pkg::CMD_CANCEL:
                        begin
                            if (slot_free)
                            begin
                                out_valid_reg <= 1'b1;
                                out_last_reg  <= 1'b1;
                                if (rm[DEPTH-1])
                                begin
                                    out_status_reg <= sdtq_pkg::ST_CANCELLED;
                                    out_id_reg     <= req_id_reg;
                                    count_reg      <= count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    out_status_reg <= sdtq_pkg::ST_NOT_FOUND;
                                    out_id_reg     <= '0;
                                end
                                state_reg <= S_IDLE;
                            end
                        end
                        sdtq_pkg::CMD_TICK:
                        begin
                            if (!due0)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else if (slot_free)
                            begin
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= sdtq_pkg::ST_FIRED;
                                out_id_reg     <= cell_q[0].id;
                                out_last_reg   <= fire_last;
                                count_reg      <= count_reg - CNT_W'(1);
                                fire_cnt_reg   <= fire_cnt_reg + FIRE_W'(1);
                                if (fire_last)
                                begin
                                    state_reg <= S_IDLE;
                                end
                            end
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // The queue never holds more entries than there are cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds queue depth");

    // An insert grows the queue by exactly one entry.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the queue by one");

    // A fired or cancelled entry shrinks the queue by exactly one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_fire || do_cancel) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("removal did not shrink the queue by one");

    // A scheduled result always carries a nonzero id.
    a_sched_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == sdtq_pkg::ST_SCHEDULED)) |->
        (out_id_reg != '0))
        else $error("scheduled result with id zero");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH    = sdtq_pkg::DEPTH;
    localparam int MAX_FIRE = sdtq_pkg::MAX_FIRE;
    localparam int SEC_W    = sdtq_pkg::SEC_W;
    localparam int NS_W     = sdtq_pkg::NS_W;
    localparam int ID_W     = sdtq_pkg::ID_W;

    localparam logic [NS_W-1:0] NS_LIMIT = sdtq_pkg::NS_LIMIT;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 190;
    localparam int QUIET_AFTER  = 150;
    localparam int CYCLE_LIMIT  = 2_000_000;

    localparam logic [SEC_W-1:0] SEC_MAX = '1;
    localparam logic [NS_W-1:0]  NS_MAX  = '1;

    // One result as the block should return it.
    typedef struct {
        logic [2:0]      status;
        logic [ID_W-1:0] id;
        logic            last;
    } timer_outcome_t;

    // Mirror of the timer table that predicts the results of each request.
    class timer_queue_mirror;
        logic [SEC_W-1:0] sec_q[DEPTH];
        logic [NS_W-1:0]  ns_q[DEPTH];
        logic [ID_W-1:0]  id_q[DEPTH];
        int               count;
        logic [ID_W-1:0]  last_id;
        timer_outcome_t   outcome_fifo[$];
        int               fault_count;

        function new();
            count       = 0;
            last_id     = '0;
            fault_count = 0;
        endfunction

        // True once a deadline has been reached at the given current time.
        function bit reached(input logic [SEC_W-1:0] s, input logic [NS_W-1:0] n,
                             input logic [SEC_W-1:0] now_s, input logic [NS_W-1:0] now_n);
            return (s < now_s) || (s == now_s && n <= now_n);
        endfunction

        function void push_outcome(input logic [2:0] status, input logic [ID_W-1:0] id,
                                   input logic last);
            timer_outcome_t item;
            item.status = status;
            item.id     = id;
            item.last   = last;
            outcome_fifo.push_back(item);
        endfunction

        // Close the gap left by an entry that leaves the table.
        function void drop_at(input int pos);
            int i;
            for (i = pos; i + 1 < count; i++)
            begin
                sec_q[i] = sec_q[i + 1];
                ns_q[i]  = ns_q[i + 1];
                id_q[i]  = id_q[i + 1];
            end
            count--;
        endfunction

        function void note_request(input logic [1:0] cmd, input logic [SEC_W-1:0] sec,
                                   input logic [NS_W-1:0] ns, input logic [ID_W-1:0] tid);
            int              pos;
            int              i;
            int              fired;
            bit              more;
            logic [ID_W-1:0] fresh;
            case (cmd)
                sdtq_pkg::CMD_SCHEDULE:
                begin
                    // The time check wins over the full check; neither uses up an id.
                    if (ns > NS_LIMIT)
                        push_outcome(sdtq_pkg::ST_INVALID, '0, 1'b1);
                    else if (count >= DEPTH)
                        push_outcome(sdtq_pkg::ST_FULL, '0, 1'b1);
                    else
                    begin
                        fresh = last_id + 1'b1;
                        if (fresh == '0)
                            fresh = ID_W'(1);
                        last_id = fresh;
                        // Equal deadlines keep their order of arrival.
                        pos = 0;
                        while (pos < count && reached(sec_q[pos], ns_q[pos], sec, ns))
                            pos++;
                        for (i = count; i > pos; i--)
                        begin
                            sec_q[i] = sec_q[i - 1];
                            ns_q[i]  = ns_q[i - 1];
                            id_q[i]  = id_q[i - 1];
                        end
                        sec_q[pos] = sec;
                        ns_q[pos]  = ns;
                        id_q[pos]  = fresh;
                        count++;
                        push_outcome(sdtq_pkg::ST_SCHEDULED, fresh, 1'b1);
                    end
                end
                sdtq_pkg::CMD_CANCEL:
                begin
                    // Id zero never matches; with duplicate ids the one nearest the head goes.
                    pos = 0;
                    while (pos < count && (tid == '0 || id_q[pos] != tid))
                        pos++;
                    if (pos < count)
                    begin
                        drop_at(pos);
                        push_outcome(sdtq_pkg::ST_CANCELLED, tid, 1'b1);
                    end
                    else
                        push_outcome(sdtq_pkg::ST_NOT_FOUND, '0, 1'b1);
                end
                sdtq_pkg::CMD_TICK:
                begin
                    // Fire due entries from the head, up to the per-tick limit.
                    fired = 0;
                    more  = count > 0 && reached(sec_q[0], ns_q[0], sec, ns);
                    while (more)
                    begin
                        fresh = id_q[0];
                        drop_at(0);
                        fired++;
                        more = fired < MAX_FIRE && count > 0
                               && reached(sec_q[0], ns_q[0], sec, ns);
                        push_outcome(sdtq_pkg::ST_FIRED, fresh, !more);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void flag_mismatch(input string field, input int want, input int got);
            fault_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void check_outcome(input logic [2:0] status, input logic [ID_W-1:0] id,
                                    input logic last);
            timer_outcome_t want;
            if (outcome_fifo.size() == 0)
            begin
                fault_count++;
                $display("%0t: result mismatch, expected none, got status %0d id %0d last %0d",
                         $time, status, id, last);
                return;
            end
            want = outcome_fifo.pop_front();
            if (status !== want.status)
                flag_mismatch("status", want.status, status);
            if (id !== want.id)
                flag_mismatch("result_id", want.id, id);
            if (last !== want.last)
                flag_mismatch("last_result", want.last, last);
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = sdtq_pkg::CMD_SCHEDULE;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    timer_queue_mirror mirror = new();

    int send_odds      = 0;
    int stall_odds     = 0;
    int stall_left     = 0;
    int accepted_count = 0;
    int cycle_count    = 0;

    sorted_deadline_timer_queue dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Check each accepted result and stall the result side in random bursts.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_outcome(m_tuser, m_tdata, m_tlast);
        if (stall_left > 1)
            stall_left <= stall_left - 1;
        else if (stall_left == 1)
        begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left <= $urandom_range(1, 10);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Hand one request to the block, after an optional gap, and predict its results.
    task automatic post_request(input logic [1:0] cmd, input logic [SEC_W-1:0] sec,
                                input logic [NS_W-1:0] ns, input logic [ID_W-1:0] tid);
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, tid, ns, sec};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        mirror.note_request(cmd, sec, ns, tid);
        if (cmd != CMD_UNUSED)
            accepted_count++;
    endtask

    // Hold back requests until every predicted result has come out.
    task automatic settle_outputs();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (mirror.outcome_fifo.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_odds();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 10);
    endfunction

    // Deadline nanoseconds, weighted toward ties and the range boundary.
    function automatic logic [NS_W-1:0] deadline_ns();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return NS_LIMIT;
            2:       return NS_W'(500_000_000);
            3:       return NS_W'(NS_LIMIT + 1 + $urandom_range(0, NS_MAX - NS_LIMIT - 1));
            default: return NS_W'($urandom_range(0, NS_LIMIT));
        endcase
    endfunction

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int               kind;
        int               burst;
        int               before_count;
        int               random_sent;
        bit               pressure_done;
        bit               quiet_done;
        logic [ID_W-1:0]  tid;
        logic [SEC_W-1:0] epoch;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: empty table, range boundary, ties, misses, ignored command.
        post_request(sdtq_pkg::CMD_TICK, '0, '0, '0);
        post_request(sdtq_pkg::CMD_CANCEL, '0, '0, '0);
        post_request(sdtq_pkg::CMD_SCHEDULE, 5, NS_LIMIT, '0);
        post_request(sdtq_pkg::CMD_SCHEDULE, 5, NS_W'(NS_LIMIT + 1), '1);
        post_request(sdtq_pkg::CMD_SCHEDULE, SEC_MAX, NS_MAX, '1);
        post_request(sdtq_pkg::CMD_SCHEDULE, SEC_MAX, NS_LIMIT, '0);
        post_request(sdtq_pkg::CMD_SCHEDULE, '0, '0, '0);
        post_request(sdtq_pkg::CMD_SCHEDULE, 5, NS_LIMIT, '0);
        post_request(sdtq_pkg::CMD_SCHEDULE, 5, '0, '0);
        post_request(sdtq_pkg::CMD_CANCEL, '0, '0, '1);
        post_request(sdtq_pkg::CMD_CANCEL, '0, '0, ID_W'(1));
        post_request(CMD_UNUSED, SEC_MAX, NS_MAX, '1);
        post_request(sdtq_pkg::CMD_TICK, 5, NS_W'(999_999_999), '0);
        post_request(sdtq_pkg::CMD_TICK, 5, NS_MAX, '0);
        post_request(sdtq_pkg::CMD_CANCEL, '1, NS_MAX, ID_W'(4));
        post_request(sdtq_pkg::CMD_TICK, SEC_MAX, NS_MAX, '1);
        post_request(sdtq_pkg::CMD_TICK, SEC_MAX, NS_MAX, '1);

        // Random sequences: mostly bursts of schedules, then ticks and cancels.
        epoch         = $urandom();
        random_sent   = 0;
        pressure_done = 1'b0;
        quiet_done    = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (!pressure_done && random_sent >= RANDOM_ITEMS / 3)
            begin
                settle_outputs();
                pressure_done = 1'b1;
            end
            // The last part of the run goes without idling on either side.
            if (!quiet_done && random_sent >= QUIET_AFTER)
            begin
                send_odds  = 0;
                stall_odds = 0;
                quiet_done = 1'b1;
            end
            if (!quiet_done)
            begin
                send_odds  = pick_odds();
                stall_odds = pick_odds();
            end
            before_count = accepted_count;
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3:
                begin
                    if ($urandom_range(0, 3) == 0)
                        epoch = $urandom();
                    burst = $urandom_range(3, 20);
                    repeat (burst)
                        post_request(sdtq_pkg::CMD_SCHEDULE, epoch + $urandom_range(0, 3),
                                     deadline_ns(), ID_W'($urandom()));
                end
                4, 5:
                    post_request(sdtq_pkg::CMD_TICK, epoch + $urandom_range(0, 3),
                                 $urandom_range(0, 1) ? deadline_ns() : NS_W'($urandom()),
                                 ID_W'($urandom()));
                6, 7:
                    repeat ($urandom_range(1, 3))
                    begin
                        if (mirror.count != 0 && $urandom_range(0, 2) != 0)
                            tid = mirror.id_q[$urandom_range(0, mirror.count - 1)];
                        else if ($urandom_range(0, 4) == 0)
                            tid = '0;
                        else
                            tid = ID_W'($urandom());
                        post_request(sdtq_pkg::CMD_CANCEL, $urandom(), NS_W'($urandom()),
                                     tid);
                    end
                8:
                    post_request(sdtq_pkg::CMD_TICK,
                                 $urandom_range(0, 1) ? SEC_MAX : $urandom(),
                                 $urandom_range(0, 1) ? NS_MAX : NS_W'($urandom()),
                                 ID_W'($urandom()));
                default:
                    if ($urandom_range(0, 1) == 0)
                        post_request(CMD_UNUSED, $urandom(), NS_W'($urandom()),
                                     ID_W'($urandom()));
                    else
                        post_request(sdtq_pkg::CMD_SCHEDULE, $urandom(),
                                     NS_W'(NS_LIMIT + 1
                                           + $urandom_range(0, NS_MAX - NS_LIMIT - 1)),
                                     ID_W'($urandom()));
            endcase
            random_sent += accepted_count - before_count;
        end

        // Drain, then give a tick that fires nothing time to finish.
        settle_outputs();
        repeat (40) @(posedge clk);
        if (mirror.fault_count == 0 && mirror.outcome_fifo.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/sdtq_pkg.sv
sv/sdtq_cell.sv
sv/sorted_deadline_timer_queue.sv
verif/testbench.sv
